/* sv/descriptor_range_free_list_allocator_defines.svh */
// Assertion macros used by the allocator back end.
`ifndef DESCRIPTOR_RANGE_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define DESCRIPTOR_RANGE_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define DRFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define DRFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* sv/drfa_pkg.sv */
// Types and codes shared by the range free-list allocator modules.
package drfa_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_FREE_NOP = 2'd2,
    OP_BAD_HEAP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_HEAP  = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_HEAP = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ACHK,
    S_SRD,
    S_SWR,
    S_FRD,
    S_FCHK
  } state_e;

  localparam int unsigned SlotW   = 8;
  localparam int unsigned HeapW   = 2;
  localparam int unsigned StrideW = 7;
  localparam int unsigned OffW    = 14;

  typedef struct packed {
    op_e              op;
    logic [SlotW-1:0] slot;
    logic [HeapW-1:0] heap;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_out_t;

  typedef struct packed {
    logic pop;
    logic init;
  } back_ctl_t;

endpackage

/* sv/drfa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module drfa_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/drfa_front.sv */
// Front end: take commands, classify them and hold them in a two-entry queue.
module drfa_front import drfa_pkg::*; #(
  parameter int unsigned HEAP_SLOTS = 256,
  parameter int unsigned MAX_HEAPS  = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             command_i,
  input  logic [SlotW-1:0] slot_i,
  input  logic [HeapW-1:0] heap_i,
  output queue_out_t       q_o,
  input  back_ctl_t        ctl_i
);

  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  cmd_t       buf_q [2];
  cmd_t       cmd_in;
  logic       push, pop;

  always_comb begin
    cmd_in.slot = slot_i;
    cmd_in.heap = heap_i;
    if (!command_i) begin
      cmd_in.op = OP_ALLOC;
    end else if (32'(heap_i) >= MAX_HEAPS) begin
      cmd_in.op = OP_BAD_HEAP;
    end else if (32'(slot_i) >= HEAP_SLOTS) begin
      cmd_in.op = OP_FREE_NOP;
    end else begin
      cmd_in.op = OP_FREE;
    end
  end

  assign busy = (fill_q == 2'd2) || ctl_i.init;
  assign push = start && !busy;
  assign pop  = ctl_i.pop && (fill_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = 2'(fill_q + {1'b0, push} - {1'b0, pop});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign q_o.valid = (fill_q != 2'd0);
  assign q_o.cmd   = buf_q[rd_ptr_q];

endmodule

/* sv/drfa_back.sv */
// Back end: execute allocate and free commands against the range tables.
`include "descriptor_range_free_list_allocator_defines.svh"
module drfa_back import drfa_pkg::*; #(
  parameter int unsigned HEAP_SLOTS = 256,
  parameter int unsigned MAX_HEAPS  = 4,
  parameter int unsigned MAX_RANGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  queue_out_t         q_i,
  output back_ctl_t          ctl_o,
  input  logic [StrideW-1:0] stride_i,
  output logic               done_o,
  output status_e            status_o,
  output logic [HeapW-1:0]   heap_index_o,
  output logic [SlotW-1:0]   slot_index_o,
  output logic [OffW-1:0]    handle_offset_o
);

  localparam int unsigned W     = $clog2(HEAP_SLOTS + 1);
  localparam int unsigned HW    = (MAX_HEAPS > 1) ? $clog2(MAX_HEAPS) : 1;
  localparam int unsigned RI    = $clog2(MAX_RANGES);
  localparam int unsigned CW    = $clog2(MAX_RANGES + 1);
  localparam int unsigned OW    = $clog2(MAX_HEAPS + 1);
  localparam int unsigned DEPTH = MAX_HEAPS * MAX_RANGES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = (W + StrideW > OffW) ? W + StrideW : OffW;

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q [MAX_HEAPS];
  logic [CW-1:0]   cnt_d [MAX_HEAPS];
  logic [OW-1:0]   open_q, open_d;
  logic [HW-1:0]   h_q, h_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [W-1:0]    slot_q, slot_d;
  logic            res_vld_q, res_vld_d;
  status_e         res_st_q, res_st_d;
  logic [HeapW-1:0] res_h_q, res_h_d;
  logic [SlotW-1:0] res_s_q, res_s_d;
  logic [OffW-1:0] res_off_q, res_off_d;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [2*W-1:0]  wdata, rdata;
  logic [W-1:0]    rd_b, rd_e;
  logic            found;
  logic [HW-1:0]   f_h;
  logic [W-1:0]    fin_slot;
  logic [PW-1:0]   prod;
  logic [HW-1:0]   q_h;
  logic [CW-1:0]   idx_m1;

  function automatic logic [AW-1:0] addr_of(logic [HW-1:0] h, logic [RI-1:0] i);
    addr_of = AW'(32'(h) * MAX_RANGES + 32'(i));
  endfunction

  drfa_ram #(.WIDTH(2 * W), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_b   = rdata[2*W-1:W];
  assign rd_e   = rdata[W-1:0];
  assign q_h    = HW'(32'(q_i.cmd.heap));
  assign idx_m1 = CW'(idx_q - 1'b1);

  // First open heap with a non-empty table.
  always_comb begin
    found = 1'b0;
    f_h   = '0;
    for (int h = MAX_HEAPS - 1; h >= 0; h--) begin
      if (32'(h) < 32'(open_q) && cnt_q[h] != '0) begin
        found = 1'b1;
        f_h   = HW'(h);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    open_d    = open_q;
    h_d       = h_q;
    idx_d     = idx_q;
    slot_d    = slot_q;
    res_vld_d = 1'b0;
    res_st_d  = res_st_q;
    res_h_d   = res_h_q;
    res_s_d   = res_s_q;
    fin_slot  = '0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    raddr     = addr_of(h_q, idx_q[RI-1:0]);
    ctl_o.pop = 1'b0;
    ctl_o.init = (state_q == S_INIT);

    case (state_q)
      S_INIT: begin
        we      = 1'b1;
        waddr   = '0;
        wdata   = {W'(0), W'(HEAP_SLOTS)};
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (q_i.valid) begin
          ctl_o.pop = 1'b1;
          case (q_i.cmd.op)
            OP_ALLOC: begin
              if (found) begin
                h_d     = f_h;
                raddr   = addr_of(f_h, '0);
                state_d = S_ACHK;
              end else if (32'(open_q) >= MAX_HEAPS) begin
                res_vld_d = 1'b1;
                res_st_d  = ST_NO_HEAP;
                res_h_d   = '0;
              end else begin
                // Open the next heap and hand out its slot zero.
                we        = 1'b1;
                waddr     = addr_of(HW'(open_q), '0);
                wdata     = {W'(1), W'(HEAP_SLOTS)};
                cnt_d[HW'(open_q)] = CW'(1);
                open_d    = OW'(open_q + 1'b1);
                res_vld_d = 1'b1;
                res_st_d  = ST_OK;
                res_h_d   = HeapW'(open_q);
              end
            end
            default: begin
              if (q_i.cmd.op == OP_BAD_HEAP || 32'(q_i.cmd.heap) >= 32'(open_q)) begin
                res_vld_d = 1'b1;
                res_st_d  = ST_BAD_HEAP;
                res_h_d   = '0;
              end else if (q_i.cmd.op == OP_FREE_NOP) begin
                res_vld_d = 1'b1;
                res_st_d  = ST_OK;
                res_h_d   = '0;
              end else begin
                h_d     = q_h;
                slot_d  = W'(q_i.cmd.slot);
                idx_d   = '0;
                state_d = S_FRD;
              end
            end
          endcase
        end
      end
      S_ACHK: begin
        if ((W + 1)'(rd_b) + 1'b1 < (W + 1)'(rd_e)) begin
          we        = 1'b1;
          waddr     = addr_of(h_q, '0);
          wdata     = {W'(rd_b + 1'b1), rd_e};
          res_vld_d = 1'b1;
          res_st_d  = ST_OK;
          res_h_d   = HeapW'(h_q);
          fin_slot  = rd_b;
          state_d   = S_IDLE;
        end else begin
          // Front range is used up: shift the rest of the table down.
          slot_d  = rd_b;
          idx_d   = CW'(1);
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        if (idx_q < cnt_q[h_q]) begin
          state_d = S_SWR;
        end else begin
          cnt_d[h_q] = CW'(cnt_q[h_q] - 1'b1);
          res_vld_d  = 1'b1;
          res_st_d   = ST_OK;
          res_h_d    = HeapW'(h_q);
          fin_slot   = slot_q;
          state_d    = S_IDLE;
        end
      end
      S_SWR: begin
        we      = 1'b1;
        waddr   = addr_of(h_q, idx_m1[RI-1:0]);
        wdata   = rdata;
        idx_d   = CW'(idx_q + 1'b1);
        state_d = S_SRD;
      end
      S_FRD: begin
        if (idx_q < cnt_q[h_q]) begin
          state_d = S_FCHK;
        end else if (32'(cnt_q[h_q]) >= MAX_RANGES) begin
          res_vld_d = 1'b1;
          res_st_d  = ST_FULL;
          res_h_d   = '0;
          state_d   = S_IDLE;
        end else begin
          // Append a one-slot range.
          we         = 1'b1;
          waddr      = addr_of(h_q, cnt_q[h_q][RI-1:0]);
          wdata      = {slot_q, W'(slot_q + 1'b1)};
          cnt_d[h_q] = CW'(cnt_q[h_q] + 1'b1);
          res_vld_d  = 1'b1;
          res_st_d   = ST_OK;
          res_h_d    = '0;
          state_d    = S_IDLE;
        end
      end
      S_FCHK: begin
        if (W'(slot_q + 1'b1) == rd_b) begin
          we        = 1'b1;
          waddr     = addr_of(h_q, idx_q[RI-1:0]);
          wdata     = {slot_q, rd_e};
          res_vld_d = 1'b1;
          res_st_d  = ST_OK;
          res_h_d   = '0;
          state_d   = S_IDLE;
        end else if (slot_q == rd_e) begin
          we        = 1'b1;
          waddr     = addr_of(h_q, idx_q[RI-1:0]);
          wdata     = {rd_b, W'(slot_q + 1'b1)};
          res_vld_d = 1'b1;
          res_st_d  = ST_OK;
          res_h_d   = '0;
          state_d   = S_IDLE;
        end else begin
          idx_d   = CW'(idx_q + 1'b1);
          state_d = S_FRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    prod      = PW'(fin_slot) * PW'(stride_i);
    res_off_d = prod[OffW-1:0];
    res_s_d   = SlotW'(fin_slot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      open_q    <= OW'(1);
      res_vld_q <= 1'b0;
      for (int h = 0; h < MAX_HEAPS; h++) begin
        cnt_q[h] <= (h == 0) ? CW'(1) : '0;
      end
    end else begin
      state_q   <= state_d;
      open_q    <= open_d;
      res_vld_q <= res_vld_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q       <= h_d;
    idx_q     <= idx_d;
    slot_q    <= slot_d;
    res_st_q  <= res_st_d;
    res_h_q   <= res_h_d;
    res_s_q   <= res_s_d;
    res_off_q <= res_off_d;
  end

  assign done_o          = res_vld_q;
  assign status_o        = res_st_q;
  assign heap_index_o    = res_h_q;
  assign slot_index_o    = res_s_q;
  assign handle_offset_o = res_off_q;

  `DRFA_ASSERT(a_open_range, (open_q >= OW'(1)) && (32'(open_q) <= MAX_HEAPS),
               "open heap count out of range")
  `DRFA_ASSERT_IMP(a_done_idle, res_vld_q, state_q == S_IDLE,
                   "result shown while a command is still in flight")
  `DRFA_ASSERT_IMP(a_chk_after_rd, state_q == S_FCHK, $past(state_q) == S_FRD,
                   "range compare without a preceding read")

endmodule

/* sv/descriptor_range_free_list_allocator.sv */
// Top level of the descriptor range free-list allocator.
//
// Commands enter on start/busy: a command is taken at a clock edge with start
// high and busy low. command_i = 0 allocates one slot; command_i = 1 frees
// slot_i of heap heap_i. Each command yields exactly one result, shown for one
// cycle with done_o high: status_o, heap_index_o, slot_index_o and
// handle_offset_o (slot times descriptor stride). The receiver cannot stall,
// so results never back up.
// A front end classifies commands into a two-entry queue; the back end walks
// the range tables in a RAM with one read and one write port. An allocate
// takes the front slot of the first open heap with a non-empty table, else
// opens the next heap or fails if all are open; it shifts the remaining
// ranges down when its front range empties. A free reads the table one entry
// at a time to extend a range, else appends a one-slot range or finds the
// table full; a free rejected on its heap or slot makes no table access.
// Reset opens heap 0 with one full range; a one-cycle initialization pass
// then writes that entry, during which busy is high.
// The stride register is written on cfg_valid_i/cfg_ready_o; the user must
// write it only while idle, which the block does not enforce. cfg_ready_o
// is always high.
module descriptor_range_free_list_allocator import drfa_pkg::*; #(
  parameter int unsigned HEAP_SLOTS = 256,
  parameter int unsigned MAX_HEAPS  = 4,
  parameter int unsigned MAX_RANGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               command_i,
  input  logic [SlotW-1:0]   slot_i,
  input  logic [HeapW-1:0]   heap_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [StrideW-1:0] cfg_data_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [HeapW-1:0]   heap_index_o,
  output logic [SlotW-1:0]   slot_index_o,
  output logic [OffW-1:0]    handle_offset_o
);

  logic [StrideW-1:0] stride_q;
  queue_out_t         q;
  back_ctl_t          ctl;
  status_e            status;

  // Stride register: take each configuration beat at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= StrideW'(32);
    end else if (cfg_valid_i && cfg_ready_o) begin
      stride_q <= cfg_data_i;
    end
  end

  drfa_front #(
    .HEAP_SLOTS (HEAP_SLOTS),
    .MAX_HEAPS  (MAX_HEAPS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .command_i (command_i),
    .slot_i    (slot_i),
    .heap_i    (heap_i),
    .q_o       (q),
    .ctl_i     (ctl)
  );

  drfa_back #(
    .HEAP_SLOTS (HEAP_SLOTS),
    .MAX_HEAPS  (MAX_HEAPS),
    .MAX_RANGES (MAX_RANGES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_i             (q),
    .ctl_o           (ctl),
    .stride_i        (stride_q),
    .done_o          (done_o),
    .status_o        (status),
    .heap_index_o    (heap_index_o),
    .slot_index_o    (slot_index_o),
    .handle_offset_o (handle_offset_o)
  );

  assign status_o = status;

endmodule
